FILE: rtl/bira_pkg.sv
// Shared types and constants for the beat interval rate averager.
`default_nettype none

package bira_pkg;

    // Fixed field widths
    localparam int RATE_W     = 16;
    localparam int MIN_IVL_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd1;

    // Reset values of the configuration registers
    localparam logic [MIN_IVL_W-1:0]  MIN_INTERVAL_RST   = 8'd2;
    localparam logic [CFG_DATA_W-1:0] RATE_NUMERATOR_RST = 16'd600;

    localparam logic [RATE_W-1:0] RATE_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_RATE_LOAD,
        ST_RATE_DIV,
        ST_DONE
    } bira_state_t;

endpackage

`default_nettype wire

FILE: rtl/beat_interval_rate_averager.sv
// Top level of the beat interval rate averager: interval ring, running sum, serial divider.
//
// Usage:
//   s_ channel: one capture timestamp per beat transaction. The interval to the
//   previous capture (modulo 2^TIME_BITS) is stored in a WINDOW-entry ring when it
//   is at least min_interval; shorter intervals give no result.
//   m_ channel: one result per stored interval: beat_rate, average_interval and
//   samples_used.
//   cfg channel: register writes (index 0 min_interval, index 1 rate_numerator),
//   always ready; write only while the block is idle.
// Sequencing:
//   A stored beat runs the mean division over the SUM_W sum bits, then loads and runs
//   the rate division, which a zero average skips, then waits to load the output;
//   SUM_W = TIME_BITS + clog2(WINDOW). One restoring divider, one quotient bit per
//   cycle, serves the mean and then the rate. The next input can be taken in the same
//   cycle as m_tvalid rises; a dropped beat leaves the block idle for the next beat.
//   s_tready is high only while the divider is free.
// Reset: clears the ring, running sum, previous capture and fill state, and loads
//   min_interval = 2 and rate_numerator = 600.
// Stall: a finished result waits in the output register; a new beat may still be
//   taken, and its result holds in the divider until the output register frees.
`default_nettype none

module beat_interval_rate_averager
    import bira_pkg::*;
#(
    parameter int WINDOW    = 10,
    parameter int TIME_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // tdata: capture_time [TIME_BITS-1:0]
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((TIME_BITS+7)/8)*8-1:0] s_tdata,
    // tdata: beat_rate [15:0], average_interval [TIME_BITS+15:16],
    //        samples_used [above average_interval]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [((RATE_W+TIME_BITS+$clog2(WINDOW+1)+7)/8)*8-1:0] m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int USED_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = TIME_BITS + $clog2(WINDOW);
    localparam int DIV_W   = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int DVS_W   = (TIME_BITS > USED_W) ? TIME_BITS : USED_W;
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int OUT_RAW = RATE_W + TIME_BITS + USED_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    bira_state_t state_reg, state_next;

    logic [MIN_IVL_W-1:0]  min_interval_reg;
    logic [CFG_DATA_W-1:0] rate_numerator_reg;

    logic [TIME_BITS-1:0] prev_time_reg;
    logic [TIME_BITS-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0]    write_slot_reg;
    logic                 window_full_reg;
    logic [SUM_W-1:0]     sum_reg;

    logic [DIV_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] avg_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [USED_W-1:0]    used_reg;

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic [TIME_BITS-1:0] capture_time;
    logic [TIME_BITS-1:0] interval;
    logic                 short_interval;
    logic                 beat_accept;
    logic                 beat_store;
    logic [SLOT_W-1:0]    slot;
    logic [SLOT_W-1:0]    write_slot_next;
    logic                 window_full_next;
    logic [SUM_W-1:0]     sum_next;
    logic [USED_W-1:0]    used_next;
    logic                 out_load;

    logic [DVS_W:0]       rem_shift;
    logic [DVS_W:0]       rem_diff;
    logic                 q_bit;
    logic [DIV_W-1:0]     quo_step;
    logic [DVS_W-1:0]     rem_step;

    assign capture_time   = s_tdata[TIME_BITS-1:0];
    assign interval       = capture_time - prev_time_reg;
    assign short_interval = (interval < TIME_BITS'(min_interval_reg));
    assign beat_accept    = s_tvalid && s_tready;
    assign beat_store     = beat_accept && !short_interval;

    assign slot = (32'(write_slot_reg) < WINDOW) ? write_slot_reg : '0;

    always_comb begin
        if (32'(slot) == WINDOW - 1) begin
            write_slot_next  = '0;
            window_full_next = 1'b1;
        end else begin
            write_slot_next  = slot + 1'b1;
            window_full_next = window_full_reg;
        end
    end

    assign sum_next  = sum_reg - SUM_W'(ring_reg[slot]) + SUM_W'(interval);
    assign used_next = window_full_next ? USED_W'(WINDOW) : USED_W'(write_slot_next);

    // Restoring divider step: bring down the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = !rem_diff[DVS_W];
    assign quo_step  = {quo_reg[DIV_W-2:0], q_bit};
    assign rem_step  = q_bit ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (beat_store) begin
                    state_next = ST_AVG_DIV;
                end
            end
            ST_AVG_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_RATE_LOAD;
                end
            end
            ST_RATE_LOAD: begin
                state_next = (avg_reg == '0) ? ST_DONE : ST_RATE_DIV;
            end
            ST_RATE_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg   <= MIN_INTERVAL_RST;
            rate_numerator_reg <= RATE_NUMERATOR_RST;
            prev_time_reg      <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            write_slot_reg     <= '0;
            window_full_reg    <= 1'b0;
            sum_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_INTERVAL:   min_interval_reg   <= cfg_data[MIN_IVL_W-1:0];
                    CFG_RATE_NUMERATOR: rate_numerator_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (beat_accept) begin
                prev_time_reg <= capture_time;
            end
            if (beat_store) begin
                ring_reg[slot]  <= interval;
                write_slot_reg  <= write_slot_next;
                window_full_reg <= window_full_next;
                sum_reg         <= sum_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Divider and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (beat_store) begin
                    // left-align the sum so SUM_W steps walk its bits MSB first
                    quo_reg  <= DIV_W'(sum_next) << (DIV_W - SUM_W);
                    rem_reg  <= '0;
                    dvs_reg  <= DVS_W'(used_next);
                    cnt_reg  <= CNT_W'(SUM_W);
                    used_reg <= used_next;
                end
            end
            ST_AVG_DIV: begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    avg_reg <= quo_step[TIME_BITS-1:0];
                end
            end
            ST_RATE_LOAD: begin
                quo_reg  <= DIV_W'(rate_numerator_reg) << (DIV_W - RATE_W);
                rem_reg  <= '0;
                dvs_reg  <= DVS_W'(avg_reg);
                cnt_reg  <= CNT_W'(RATE_W);
                rate_reg <= RATE_SAT;
            end
            ST_RATE_DIV: begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    rate_reg <= quo_step[RATE_W-1:0];
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tdata_reg <= OUT_W'({used_reg, avg_reg, rate_reg});
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bira_checker.sv
// Port-level checker for the beat interval rate averager, with its bind.
`default_nettype none

module bira_checker
    import bira_pkg::*;
#(
    parameter int WINDOW    = 10,
    parameter int TIME_BITS = 8
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((RATE_W+TIME_BITS+$clog2(WINDOW+1)+7)/8)*8-1:0] m_tdata
);

    localparam int USED_W = $clog2(WINDOW + 1);
    localparam int AVG_LO = RATE_W;
    localparam int USED_LO = RATE_W + TIME_BITS;

    logic [RATE_W-1:0]    rate_f;
    logic [TIME_BITS-1:0] avg_f;
    logic [USED_W-1:0]    used_f;

    assign rate_f = m_tdata[RATE_W-1:0];
    assign avg_f  = m_tdata[USED_LO-1:AVG_LO];
    assign used_f = m_tdata[USED_LO+USED_W-1:USED_LO];

    // a stalled result transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (used_f != '0) && (32'(used_f) <= WINDOW))
        else $error("samples_used out of range");

    a_zero_avg_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (avg_f == '0) |-> rate_f == RATE_SAT)
        else $error("zero average without saturated rate");

endmodule

bind beat_interval_rate_averager bira_checker #(
    .WINDOW    (WINDOW),
    .TIME_BITS (TIME_BITS)
) u_bira_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
